[hdl/dlhq_pkg.sv]
package dlhq_pkg;

  // widths fixed by the register and field formats
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned DistWidth    = 16;
  localparam int unsigned CountWidthDefault = 16;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] RegNearLevel  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegWarnLevel  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegHysteresis = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegEnterCount = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegExitCount  = 3'd4;

  // register reset values
  localparam logic [CfgDataWidth-1:0] NearLevelReset  = 16'd3000;
  localparam logic [CfgDataWidth-1:0] WarnLevelReset  = 16'd4000;
  localparam logic [CfgDataWidth-1:0] HysteresisReset = 16'd200;
  localparam logic [CfgDataWidth-1:0] EnterCountReset = 16'd2;
  localparam logic [CfgDataWidth-1:0] ExitCountReset  = 16'd300;

  // full register set
  typedef struct packed {
    logic [CfgDataWidth-1:0] near_level;
    logic [CfgDataWidth-1:0] warn_level;
    logic [CfgDataWidth-1:0] hysteresis;
    logic [CfgDataWidth-1:0] enter_count;
    logic [CfgDataWidth-1:0] exit_count;
  } cfg_t;

  // settings seen by one level channel
  typedef struct packed {
    logic [CfgDataWidth-1:0] level;
    logic [CfgDataWidth-1:0] hysteresis;
    logic [CfgDataWidth-1:0] enter_count;
    logic [CfgDataWidth-1:0] exit_count;
  } chan_cfg_t;

endpackage

[hdl/dlhq_cfg_regs.sv]
module dlhq_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dlhq_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [dlhq_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output dlhq_pkg::cfg_t                      cfg_o
);
  import dlhq_pkg::*;

  cfg_t cfg_q, cfg_d;

  // decode the write, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegNearLevel:  cfg_d.near_level  = cfg_data_i;
        RegWarnLevel:  cfg_d.warn_level  = cfg_data_i;
        RegHysteresis: cfg_d.hysteresis  = cfg_data_i;
        RegEnterCount: cfg_d.enter_count = cfg_data_i;
        RegExitCount:  cfg_d.exit_count  = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_level  <= NearLevelReset;
      cfg_q.warn_level  <= WarnLevelReset;
      cfg_q.hysteresis  <= HysteresisReset;
      cfg_q.enter_count <= EnterCountReset;
      cfg_q.exit_count  <= ExitCountReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/dlhq_channel.sv]
module dlhq_channel #(
  parameter int unsigned COUNT_WIDTH = dlhq_pkg::CountWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [dlhq_pkg::DistWidth-1:0]    dist_i,
  input  dlhq_pkg::chan_cfg_t               cfg_i,
  output logic                              flag_o
);
  import dlhq_pkg::*;

  localparam int unsigned CmpWidth =
    (COUNT_WIDTH > CfgDataWidth) ? COUNT_WIDTH : CfgDataWidth;

  logic                   flag_q, flag_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CfgDataWidth:0]  release_dist;
  logic                   enter_hit, exit_hit;

  // release distance at one extra bit so it never wraps
  assign release_dist = {1'b0, cfg_i.level} + {1'b0, cfg_i.hysteresis};

  // saturating increment
  assign cnt_inc = (cnt_q != {COUNT_WIDTH{1'b1}}) ? cnt_q + 1'b1 : cnt_q;

  assign enter_hit = (dist_i <= cfg_i.level) && !flag_q;
  assign exit_hit  = ({1'b0, dist_i} >= release_dist) && flag_q;

  // leaky qualification update
  always_comb begin
    flag_d = flag_q;
    cnt_d  = cnt_q;
    if (enter_hit) begin
      if (CmpWidth'(cnt_inc) >= CmpWidth'(cfg_i.enter_count)) begin
        flag_d = 1'b1;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_inc;
      end
    end else if (exit_hit) begin
      if (CmpWidth'(cnt_inc) >= CmpWidth'(cfg_i.exit_count)) begin
        flag_d = 1'b0;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_inc;
      end
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      cnt_q  <= '0;
    end else if (en_i) begin
      flag_q <= flag_d;
      cnt_q  <= cnt_d;
    end
  end

  // flag after this sample, captured by the result register
  assign flag_o = flag_d;

endmodule

[hdl/distance_level_hysteresis_qualifier_top.sv]
// channel   dir  handshake               payload
// input     in   in_valid_i/in_stall_o    distance_i[15:0]
// output    out  out_valid_o/out_stall_i  green_lamp_o, yellow_lamp_o, red_lamp_o,
//                                         level_flags_o[1:0]
// config    in   cfg_we_i                 cfg_idx_i[2:0], cfg_data_i[15:0]
//
// one request per cycle sustained while the output is not stalled; an accepted request passes
// through the input register, then the channel update into the result register
// the channel flag and counter registers set the update loop
// reset clears the channel flags, counters and valids and loads the register defaults
// a stalled result holds; the input register keeps taking requests until it is full
module distance_level_hysteresis_qualifier_top #(
  parameter int unsigned COUNT_WIDTH = dlhq_pkg::CountWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dlhq_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [dlhq_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dlhq_pkg::DistWidth-1:0]    distance_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              green_lamp_o,
  output logic                              yellow_lamp_o,
  output logic                              red_lamp_o,
  output logic [1:0]                        level_flags_o
);
  import dlhq_pkg::*;

  cfg_t                 cfg;
  chan_cfg_t            warn_cfg, near_cfg;
  logic                 s1_valid_q;
  logic [DistWidth-1:0] s1_dist_q;
  logic                 out_valid_q;
  logic [1:0]           flags_q;
  logic                 s1_adv, in_accept;
  logic                 warn_flag, near_flag;

  dlhq_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // pipeline control
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_dist_q <= distance_i;
    end
  end

  // per channel settings
  always_comb begin
    warn_cfg.level       = cfg.warn_level;
    warn_cfg.hysteresis  = cfg.hysteresis;
    warn_cfg.enter_count = cfg.enter_count;
    warn_cfg.exit_count  = cfg.exit_count;
    near_cfg.level       = cfg.near_level;
    near_cfg.hysteresis  = cfg.hysteresis;
    near_cfg.enter_count = cfg.enter_count;
    near_cfg.exit_count  = cfg.exit_count;
  end

  dlhq_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_warn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .dist_i (s1_dist_q),
    .cfg_i  (warn_cfg),
    .flag_o (warn_flag)
  );

  dlhq_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_near (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .dist_i (s1_dist_q),
    .cfg_i  (near_cfg),
    .flag_o (near_flag)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      flags_q <= {near_flag, warn_flag};
    end
  end

  // lamps, red over yellow over green
  assign out_valid_o   = out_valid_q;
  assign level_flags_o = flags_q;
  assign red_lamp_o    = flags_q[1];
  assign yellow_lamp_o = flags_q[0] && !flags_q[1];
  assign green_lamp_o  = !flags_q[0] && !flags_q[1];

  // exactly one lamp lit on a delivered result
  a_one_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot({green_lamp_o, yellow_lamp_o, red_lamp_o}))
    else $error("lamp outputs not one-hot");

  // input side only stalls while the input register holds a request
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after delivery");

endmodule
